// File: src/sldf_pkg.sv
package sldf_pkg;

	localparam int unsigned MAX_PAYLOAD = 256;

	localparam logic [7:0]  SYNC_A        = 8'hA5;
	localparam logic [7:0]  SYNC_B        = 8'h5A;
	localparam logic [7:0]  FRAME_VERSION = 8'h01;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'h1021;
	localparam logic [31:0] TIMEOUT_RESET = 32'd100;

	localparam logic [8:0] IDX_VERSION = 9'd2;
	localparam logic [8:0] IDX_MSG     = 9'd3;
	localparam logic [8:0] IDX_LEN_LO  = 9'd4;
	localparam logic [8:0] IDX_LEN_HI  = 9'd5;
	localparam logic [8:0] IDX_SEQ_LO  = 9'd6;
	localparam logic [8:0] IDX_SEQ_HI  = 9'd7;
	localparam logic [8:0] HEADER_BYTES = 9'd12;
	localparam logic [8:0] LAST_OFS     = 9'd13;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [2:0] EV_VALID   = 3'd0;
	localparam logic [2:0] EV_VERSION = 3'd1;
	localparam logic [2:0] EV_LENGTH  = 3'd2;
	localparam logic [2:0] EV_CRC     = 3'd3;
	localparam logic [2:0] EV_TIMEOUT = 3'd4;

	typedef struct packed {
		logic        op;
		logic [7:0]  data_byte;
		logic [31:0] now_ms;
	} in_req_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [7:0]  message_res;
		logic [15:0] sequence_res;
		logic [8:0]  length_res;
		logic [7:0]  command_byte;
		logic        sequence_gap;
	} out_req_t;

	function automatic logic [15:0] sldf_crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// File: src/sldf_if.sv
interface sldf_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  data_byte;
	logic [31:0] now_ms;

	modport source (output valid, output op, output data_byte, output now_ms, input ready);
	modport sink (input valid, input op, input data_byte, input now_ms, output ready);
endinterface

interface sldf_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  event_res;
	logic [7:0]  message_res;
	logic [15:0] sequence_res;
	logic [8:0]  length_res;
	logic [7:0]  command_byte;
	logic        sequence_gap;

	modport source (output valid, output event_res, output message_res, output sequence_res,
		output length_res, output command_byte, output sequence_gap, input ready);
	modport sink (input valid, input event_res, input message_res, input sequence_res,
		input length_res, input command_byte, input sequence_gap, output ready);
endinterface

// File: src/sync_length_crc_frame_deframer_core.sv
// Channel  Direction  Payload
// stream   in         op, data_byte, now_ms
// events   out        event_res, message_res, sequence_res, length_res,
//                     command_byte, sequence_gap
// cfg      in         cfg_we, cfg_wdata (frame timeout in ms)
//
// An event is presented after its request is accepted: the request waits
// in the input register and the parser result is loaded into the event register.
// One request is accepted every cycle while the event register is free or drained.
// Reset clears the parser to the sync hunt and the timeout to 100 ms.
// A stalled event holds the parser step, and the input register then fills.
module sync_length_crc_frame_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	sldf_in_if.sink     stream,
	sldf_out_if.source  events,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import sldf_pkg::*;

	logic [31:0] timeout_q;
	logic        valid_s1;
	in_req_t     item_s1;
	logic        advance;
	logic        res_valid;
	out_req_t    res;
	logic        out_valid_q;
	out_req_t    out_q;

	assign advance      = valid_s1 && (!out_valid_q || events.ready);
	assign stream.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			if (stream.valid && stream.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= res_valid;
			end else if (events.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			item_s1.op        <= stream.op;
			item_s1.data_byte <= stream.data_byte;
			item_s1.now_ms    <= stream.now_ms;
		end
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	sldf_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.timeout_ms (timeout_q),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign events.valid        = out_valid_q;
	assign events.event_res    = out_q.event_res;
	assign events.message_res  = out_q.message_res;
	assign events.sequence_res = out_q.sequence_res;
	assign events.length_res   = out_q.length_res;
	assign events.command_byte = out_q.command_byte;
	assign events.sequence_gap = out_q.sequence_gap;

endmodule

// File: src/sldf_parser.sv
module sldf_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  sldf_pkg::in_req_t  item,
	input  logic [31:0]      timeout_ms,
	output logic             res_valid,
	output sldf_pkg::out_req_t res
);
	import sldf_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT0 = 2'd0,
		PH_HUNT1 = 2'd1,
		PH_BODY  = 2'd2
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [8:0]  count_q, count_n;
	logic        prev_valid_q, prev_valid_n;
	logic [15:0] prev_seq_q, prev_seq_n;
	logic [31:0] last_time_q, last_time_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  rx_lo_q, rx_lo_n;
	logic [7:0]  version_q, version_n;
	logic [7:0]  msg_q, msg_n;
	logic [8:0]  len_q, len_n;
	logic [15:0] seq_q, seq_n;
	logic [7:0]  first_q, first_n;

	logic [7:0]  b;
	logic [15:0] crc_upd;
	logic [15:0] full_len;
	logic [8:0]  crc_lim;
	logic [8:0]  end_idx;
	logic [31:0] elapsed;
	logic        timed_out;

	assign b         = item.data_byte;
	assign crc_upd   = sldf_crc_byte(crc_q, b);
	assign full_len  = {b, len_q[7:0]};
	assign crc_lim   = len_q + HEADER_BYTES;
	assign end_idx   = len_q + LAST_OFS;
	assign elapsed   = item.now_ms - last_time_q;
	assign timed_out = elapsed > timeout_ms;

	always_comb begin
		phase_n      = phase_q;
		count_n      = count_q;
		prev_valid_n = prev_valid_q;
		prev_seq_n   = prev_seq_q;
		last_time_n  = last_time_q;
		crc_n        = crc_q;
		rx_lo_n      = rx_lo_q;
		version_n    = version_q;
		msg_n        = msg_q;
		len_n        = len_q;
		seq_n        = seq_q;
		first_n      = first_q;
		res_valid    = 1'b0;
		res          = '0;
		if (step && item.op == OP_TICK) begin
			if (phase_q != PH_HUNT0 && timed_out) begin
				phase_n       = PH_HUNT0;
				count_n       = '0;
				res_valid     = 1'b1;
				res.event_res = EV_TIMEOUT;
			end
		end else if (step) begin
			last_time_n = item.now_ms;
			unique case (phase_q)
				PH_HUNT0: begin
					if (b == SYNC_A) begin
						phase_n = PH_HUNT1;
						count_n = 9'd1;
					end
				end
				PH_HUNT1: begin
					if (b == SYNC_B) begin
						phase_n   = PH_BODY;
						count_n   = IDX_VERSION;
						crc_n     = CRC_INIT;
						rx_lo_n   = '0;
						version_n = '0;
						msg_n     = '0;
						len_n     = '0;
						seq_n     = '0;
						first_n   = '0;
					end else if (b == SYNC_A) begin
						count_n = 9'd1;
					end else begin
						phase_n = PH_HUNT0;
						count_n = '0;
					end
				end
				PH_BODY: begin
					count_n = count_q + 9'd1;
					if (count_q < crc_lim) begin
						crc_n = crc_upd;
					end
					priority if (count_q == IDX_VERSION) begin
						version_n = b;
					end else if (count_q == IDX_MSG) begin
						msg_n = b;
					end else if (count_q == IDX_LEN_LO) begin
						len_n = {1'b0, b};
					end else if (count_q == IDX_LEN_HI) begin
						if (full_len > 16'(MAX_PAYLOAD)) begin
							res_valid       = 1'b1;
							res.event_res   = EV_LENGTH;
							res.message_res = msg_q;
							if (b == SYNC_A) begin
								phase_n = PH_HUNT1;
								count_n = 9'd1;
							end else begin
								phase_n = PH_HUNT0;
								count_n = '0;
							end
						end else begin
							len_n = full_len[8:0];
						end
					end else if (count_q == IDX_SEQ_LO) begin
						seq_n = {seq_q[15:8], b};
					end else if (count_q == IDX_SEQ_HI) begin
						seq_n = {b, seq_q[7:0]};
					end else if (count_q >= HEADER_BYTES) begin
						if (count_q == HEADER_BYTES && len_q != '0) begin
							first_n = b;
						end
						if (count_q == crc_lim) begin
							rx_lo_n = b;
						end
					end else begin
						count_n = count_q + 9'd1;
					end
					if (count_q == end_idx) begin
						phase_n          = PH_HUNT0;
						count_n          = '0;
						res_valid        = 1'b1;
						res.message_res  = msg_q;
						res.sequence_res = seq_q;
						res.length_res   = len_q;
						res.command_byte = first_q;
						if (version_q != FRAME_VERSION) begin
							res.event_res = EV_VERSION;
						end else if ({b, rx_lo_q} != crc_q) begin
							res.event_res = EV_CRC;
						end else begin
							res.event_res    = EV_VALID;
							res.sequence_gap = prev_valid_q && ((seq_q - prev_seq_q) != 16'd1);
							prev_seq_n       = seq_q;
							prev_valid_n     = 1'b1;
						end
					end
				end
				default: begin
					phase_n = PH_HUNT0;
					count_n = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT0;
			count_q      <= '0;
			prev_valid_q <= 1'b0;
			last_time_q  <= '0;
		end else begin
			phase_q      <= phase_n;
			count_q      <= count_n;
			prev_valid_q <= prev_valid_n;
			last_time_q  <= last_time_n;
		end
	end

	always_ff @(posedge clk) begin
		prev_seq_q <= prev_seq_n;
		crc_q      <= crc_n;
		rx_lo_q    <= rx_lo_n;
		version_q  <= version_n;
		msg_q      <= msg_n;
		len_q      <= len_n;
		seq_q      <= seq_n;
		first_q    <= first_n;
	end

`ifndef NO_ASSERTIONS
	a_body_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> count_q >= IDX_VERSION && count_q <= end_idx)
		else $error("Frame byte count left the frame window.");

	a_timeout_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.event_res == EV_TIMEOUT |-> phase_q != PH_HUNT0 && item.op == OP_TICK)
		else $error("Timeout reported outside a frame.");

	a_gap_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.sequence_gap |-> res.event_res == EV_VALID)
		else $error("Sequence gap flagged on a rejected frame.");

	a_history_update: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.event_res == EV_VALID |=> prev_valid_q && prev_seq_q == $past(seq_q))
		else $error("Sequence history not updated after a valid frame.");

	a_result_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> step)
		else $error("Result produced without a request.");
`endif

endmodule
